FILE: sv/obc_pkg.sv
package obc_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 26;

  localparam int ITER_W     = 13;
  localparam int CAPT_W     = 8;
  localparam int BAIL_W     = 5;
  localparam int PPU_W      = 26;
  localparam int PIX_W      = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = COORD_BITS;

  // Multiplier operand: a value of magnitude below 8.0 with sign.
  localparam int ZW = FRAC_BITS + 4;
  localparam int PW = 2 * ZW;
  // Working width for sums and saturation.
  localparam int WW = ((PW > COORD_BITS) ? PW : COORD_BITS) + 2;
  // Pixel number before capping: d * scale >> (F + 8).
  localparam int PRW = COORD_BITS + PPU_W;
  localparam int QW  = PRW - FRAC_BITS - 8;

  typedef logic signed [WW-1:0] wide_t;

  localparam wide_t LIM8_W  = wide_t'(8) <<< FRAC_BITS;
  localparam wide_t LIM16_W = wide_t'(16) <<< FRAC_BITS;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(5000);
  localparam logic [CAPT_W-1:0] CAPT_RST     = CAPT_W'(8);
  localparam logic [BAIL_W-1:0] BAIL_RST     = BAIL_W'(16);
  localparam logic signed [COORD_BITS-1:0] RE_MIN_RST =
    COORD_BITS'(-(longint'(2) <<< FRAC_BITS));
  localparam logic signed [COORD_BITS-1:0] IM_MIN_RST =
    COORD_BITS'(-(longint'(11) <<< FRAC_BITS) / 10);
  localparam logic [PPU_W-1:0] PPU_RST   = PPU_W'(6818909);
  localparam logic [PIX_W-1:0] WIDTH_RST = PIX_W'(73250);
  localparam logic [PIX_W-1:0] HEIGHT_RST = PIX_W'(29300);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER = 4'd0,
    CFG_CAPT     = 4'd1,
    CFG_BAIL     = 4'd2,
    CFG_RE_MIN   = 4'd3,
    CFG_IM_MIN   = 4'd4,
    CFG_PPU      = 4'd5,
    CFG_WIDTH    = 4'd6,
    CFG_HEIGHT   = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AX_RE,
    AX_UP,
    AX_MIR
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_CAP,
    ST_CHK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] c_re;
    logic signed [COORD_BITS-1:0] c_im;
  } in_item_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic              upper_valid;
    logic [PIX_W-1:0]  mirror_pixel_y;
    logic              mirror_valid;
  } out_item_t;

  typedef struct packed {
    logic                         valid;
    axis_e                        axis;
    logic signed [COORD_BITS-1:0] v;
    logic signed [COORD_BITS-1:0] lo;
    logic [PIX_W-1:0]             count;
  } pix_req_t;

  typedef struct packed {
    logic             valid;
    axis_e            axis;
    logic [PIX_W-1:0] pix;
    logic             in_win;
  } pix_rsp_t;

  typedef struct packed {
    logic                         escape;
    logic signed [COORD_BITS-1:0] zr_next;
    logic signed [COORD_BITS-1:0] zi_next;
  } sq_res_t;

  function automatic wide_t sat(input wide_t v, input wide_t lim);
    wide_t r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: sv/obc_square_unit.sv
module obc_square_unit (
  input  logic                                  clk_i,
  input  logic                                  mul_en_i,
  input  logic signed [obc_pkg::COORD_BITS-1:0] zr_i,
  input  logic signed [obc_pkg::COORD_BITS-1:0] zi_i,
  input  logic signed [obc_pkg::COORD_BITS-1:0] cr_i,
  input  logic signed [obc_pkg::COORD_BITS-1:0] ci_i,
  input  logic [obc_pkg::BAIL_W-1:0]            bailout_i,
  output obc_pkg::sq_res_t                      res_o
);
  import obc_pkg::*;

  logic signed [ZW-1:0] ar;
  logic signed [ZW-1:0] ai;
  logic signed [PW-1:0] rr_q;
  logic signed [PW-1:0] ii_q;
  logic signed [PW-1:0] ri_q;

  wide_t zr_w, zi_w, re2, im2, cross_p, bound, t_sat, p_sat, zr_n, zi_n;
  logic  big;

  // Operands are only meaningful while |z| < 8; otherwise the escape flag wins.
  assign ar = zr_i[ZW-1:0];
  assign ai = zi_i[ZW-1:0];

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      rr_q <= ar * ar;
      ii_q <= ai * ai;
      ri_q <= ar * ai;
    end
  end

  always_comb begin
    zr_w    = wide_t'(zr_i);
    zi_w    = wide_t'(zi_i);
    re2     = wide_t'(rr_q >>> FRAC_BITS);
    im2     = wide_t'(ii_q >>> FRAC_BITS);
    // 2*re*im, floored
    cross_p = wide_t'(ri_q >>> (FRAC_BITS - 1));
    bound   = wide_t'(bailout_i) <<< FRAC_BITS;
    big     = (zr_w >= LIM8_W) || (zr_w <= -LIM8_W) ||
              (zi_w >= LIM8_W) || (zi_w <= -LIM8_W);
    t_sat   = sat(re2 - im2, LIM16_W);
    p_sat   = sat(cross_p, LIM16_W);
    zr_n    = sat(t_sat + wide_t'(cr_i), LIM8_W);
    zi_n    = sat(p_sat + wide_t'(ci_i), LIM8_W);
    res_o.escape  = big || ((re2 + im2) >= bound);
    res_o.zr_next = zr_n[COORD_BITS-1:0];
    res_o.zi_next = zi_n[COORD_BITS-1:0];
  end

endmodule

FILE: sv/obc_pixel_unit.sv
module obc_pixel_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  obc_pkg::pix_req_t          req_i,
  input  logic [obc_pkg::PPU_W-1:0]  ppu_i,
  output obc_pkg::pix_rsp_t          rsp_o
);
  import obc_pkg::*;

  logic signed [COORD_BITS:0] diff;
  logic                       s1_valid_q;
  axis_e                      s1_axis_q;
  logic [COORD_BITS-1:0]      s1_d_q;
  logic                       s1_ge_q;
  logic [PIX_W-1:0]           s1_count_q;
  logic                       s2_valid_q;
  axis_e                      s2_axis_q;
  logic [PRW-1:0]             s2_prod_q;
  logic                       s2_ge_q;
  logic [PIX_W-1:0]           s2_count_q;
  logic [QW-1:0]              q;

  assign diff = {req_i.v[COORD_BITS-1], req_i.v} - {req_i.lo[COORD_BITS-1], req_i.lo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_axis_q  <= req_i.axis;
    s1_d_q     <= diff[COORD_BITS-1:0];
    s1_ge_q    <= !diff[COORD_BITS];
    s1_count_q <= req_i.count;
    s2_axis_q  <= s1_axis_q;
    s2_prod_q  <= PRW'(s1_d_q) * PRW'(ppu_i);
    s2_ge_q    <= s1_ge_q;
    s2_count_q <= s1_count_q;
  end

  assign q = s2_prod_q[PRW-1:FRAC_BITS+8];

  always_comb begin
    rsp_o.valid  = s2_valid_q;
    rsp_o.axis   = s2_axis_q;
    rsp_o.pix    = q[PIX_W-1:0];
    rsp_o.in_win = s2_ge_q && (q < QW'(s2_count_q));
  end

endmodule

FILE: sv/buddhabrot_orbit_capture.sv
// Orbit capture for one complex point c (signed Q6.26). The point is iterated
// as z = z*z + c from z = c until the count reaches max_iterations or |z|^2
// reaches bailout_sq; at iteration capture_order the orbit value is mapped to
// pixel column and rows (for z_im and -z_im) and the orbit is dropped early
// if it falls outside the plot window. One request is taken at a time: every
// iteration runs a multiply state on the shared complex squaring multipliers
// and then a state for the add, saturate and bailout compare. When the
// capture iteration is reached, the three pixel requests pass through the
// pipelined pixel scaling multiplier. The result waits in an output register,
// so the next request is accepted while the previous result is still pending.
// Configuration writes are taken at any time but must only be made while the
// block is idle.
module buddhabrot_orbit_capture (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  obc_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output obc_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [obc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [obc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import obc_pkg::*;

  // Configuration registers
  logic [ITER_W-1:0]            max_iter_q;
  logic [CAPT_W-1:0]            capt_q;
  logic [BAIL_W-1:0]            bail_q;
  logic signed [COORD_BITS-1:0] re_min_q;
  logic signed [COORD_BITS-1:0] im_min_q;
  logic [PPU_W-1:0]             ppu_q;
  logic [PIX_W-1:0]             width_q;
  logic [PIX_W-1:0]             height_q;

  // Sequencer and orbit state
  state_e                       state_q, state_d;
  in_item_t                     c_q;
  logic signed [COORD_BITS-1:0] zr_q, zi_q;
  logic [ITER_W-1:0]            iter_q;
  axis_e                        issue_q, issue_d;
  logic                         issue_busy_q, issue_busy_d;

  // Captured pixels
  logic             x_in_q, up_in_q, mir_in_q;
  logic [PIX_W-1:0] px_q, py_q, pm_q;

  // Result register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Control
  logic     accept;
  logic     mul_en;
  logic     z_adv;
  logic     start_cap;
  logic     out_free;
  logic     plotted;
  logic     at_capt;
  logic     stop_iter;
  logic     cap_fail;
  sq_res_t  sq;
  pix_req_t pix_req;
  pix_rsp_t pix_rsp;

  obc_square_unit u_square (
    .clk_i     (clk_i),
    .mul_en_i  (mul_en),
    .zr_i      (zr_q),
    .zi_i      (zi_q),
    .cr_i      (c_q.c_re),
    .ci_i      (c_q.c_im),
    .bailout_i (bail_q),
    .res_o     (sq)
  );

  obc_pixel_unit u_pixel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pix_req),
    .ppu_i  (ppu_q),
    .rsp_o  (pix_rsp)
  );

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign at_capt   = (iter_q == ITER_W'(capt_q));
  assign stop_iter = (iter_q >= max_iter_q) || sq.escape;
  // Drop the orbit when the column is outside, or both rows are.
  assign cap_fail  = !x_in_q || (!up_in_q && !mir_in_q);
  assign plotted   = (iter_q < max_iter_q) && (iter_q > ITER_W'(capt_q));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (stop_iter) begin
          state_d = ST_FIN;
        end else if (at_capt) begin
          state_d = ST_CAP;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_CAP: begin
        if (pix_rsp.valid && (pix_rsp.axis == AX_MIR)) state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = cap_fail ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    mul_en       = 1'b0;
    z_adv        = 1'b0;
    start_cap    = 1'b0;
    issue_d      = issue_q;
    issue_busy_d = issue_busy_q;
    pix_req      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_MUL: begin
        mul_en = 1'b1;
      end
      ST_STEP: begin
        if (!stop_iter) begin
          if (at_capt) begin
            start_cap = 1'b1;
          end else begin
            z_adv = 1'b1;
          end
        end
      end
      ST_CAP: begin
        if (issue_busy_q) begin
          pix_req.valid = 1'b1;
          pix_req.axis  = issue_q;
          case (issue_q)
            AX_RE: begin
              pix_req.v     = zr_q;
              pix_req.lo    = re_min_q;
              pix_req.count = width_q;
              issue_d       = AX_UP;
            end
            AX_UP: begin
              pix_req.v     = zi_q;
              pix_req.lo    = im_min_q;
              pix_req.count = height_q;
              issue_d       = AX_MIR;
            end
            AX_MIR: begin
              pix_req.v     = -zi_q;
              pix_req.lo    = im_min_q;
              pix_req.count = height_q;
              issue_busy_d  = 1'b0;
            end
            default: begin
              pix_req.valid = 1'b0;
              issue_busy_d  = 1'b0;
            end
          endcase
        end
      end
      ST_CHK: begin
        z_adv = !cap_fail;
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
    if (start_cap) begin
      issue_d      = AX_RE;
      issue_busy_d = 1'b1;
    end
  end

  // Result assembly; rows are cleared when their flag is low
  always_comb begin
    out_d                = '0;
    out_d.iterations     = iter_q;
    out_d.pixel_x        = plotted ? px_q : '0;
    out_d.upper_valid    = plotted && up_in_q;
    out_d.pixel_y        = (plotted && up_in_q) ? py_q : '0;
    out_d.mirror_valid   = plotted && mir_in_q;
    out_d.mirror_pixel_y = (plotted && mir_in_q) ? pm_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= AX_RE;
      issue_busy_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      issue_busy_q <= issue_busy_d;
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Orbit and capture datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q    <= in_data_i;
      zr_q   <= in_data_i.c_re;
      zi_q   <= in_data_i.c_im;
      iter_q <= '0;
    end else if (z_adv) begin
      zr_q   <= sq.zr_next;
      zi_q   <= sq.zi_next;
      iter_q <= iter_q + ITER_W'(1);
    end
    if (pix_rsp.valid) begin
      case (pix_rsp.axis)
        AX_RE: begin
          x_in_q <= pix_rsp.in_win;
          px_q   <= pix_rsp.pix;
        end
        AX_UP: begin
          up_in_q <= pix_rsp.in_win;
          py_q    <= pix_rsp.pix;
        end
        AX_MIR: begin
          mir_in_q <= pix_rsp.in_win;
          pm_q     <= pix_rsp.pix;
        end
        default: begin
        end
      endcase
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_q <= out_d;
    end
  end

  // Configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      capt_q     <= CAPT_RST;
      bail_q     <= BAIL_RST;
      re_min_q   <= RE_MIN_RST;
      im_min_q   <= IM_MIN_RST;
      ppu_q      <= PPU_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ITER: max_iter_q <= cfg_data_i[ITER_W-1:0];
        CFG_CAPT:     capt_q     <= cfg_data_i[CAPT_W-1:0];
        CFG_BAIL:     bail_q     <= cfg_data_i[BAIL_W-1:0];
        CFG_RE_MIN:   re_min_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_IM_MIN:   im_min_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_PPU:      ppu_q      <= cfg_data_i[PPU_W-1:0];
        CFG_WIDTH:    width_q    <= cfg_data_i[PIX_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_data_i[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Hold off new requests once one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Pixel results only come back while the capture is being scaled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_rsp.valid |-> (state_q == ST_CAP))
    else $error("pixel response outside capture");

  // The capture check only runs at the capture iteration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (iter_q == ITER_W'(capt_q)))
    else $error("capture check at wrong iteration");

  // A row without its flag reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.upper_valid |-> (out_data_o.pixel_y == '0))
    else $error("upper row set without flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.mirror_valid |-> (out_data_o.mirror_pixel_y == '0))
    else $error("mirror row set without flag");

endmodule
